### sv/sfm_pkg.sv
// shared types and constants for the substring first-match search
// no dependencies

package sfm_pkg;

  localparam int PatternMax    = 8;
  localparam int PositionWidth = 16;
  localparam int RecentWidth   = 8 * (PatternMax - 1);
  localparam int LenWidth      = 4;
  localparam int TextLenWidth  = 16;
  localparam int StartWidth    = 17;
  localparam int AddrWidth     = 5;
  localparam int DataWidth     = 64;

  localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] REG_TEXT_LENGTH    = 2'd2;
  localparam logic [1:0] REG_START_INDEX    = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic [PositionWidth-1:0] first_position;
    logic [PositionWidth-1:0] last_position;
  } out_item_t;

endpackage

### sv/substring_first_match_unit.sv
// substring first-match search over a byte stream, with apb register port
// depends on sfm_pkg
// a result is registered in the output stage as the byte that causes it leaves the byte stage
// throughput: one byte per cycle; a held result does not block intake until the
//   byte stage also holds a result
// reset: rst_n synchronous active low, clears registers, stream state and valids

module substring_first_match_unit
  import sfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  logic [DataWidth-1:0]     pat_bytes_r;
  logic [LenWidth-1:0]      pat_len_r;
  logic [TextLenWidth-1:0]  text_len_r;
  logic [StartWidth-1:0]    start_idx_r;

  logic                     s1_valid_r;
  in_item_t                 s1_data_r;
  logic [RecentWidth-1:0]   recent_r;
  logic [PositionWidth-1:0] pos_r;
  logic                     reported_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic [1:0]               reg_sel;
  logic                     cfg_wr;
  logic [DataWidth-1:0]     window;
  logic                     beyond;
  logic [PositionWidth-1:0] pos_nxt;
  logic [StartWidth:0]      start_ext;
  logic [StartWidth:0]      start_adj;
  logic [StartWidth-1:0]    start_res;
  logic [PositionWidth-1:0] first0;
  logic [PatternMax:1]      len_match;
  logic                     win_match;
  logic                     match;
  logic                     emit;
  logic                     s1_adv;
  logic                     in_accept;

  assign reg_sel = paddr[AddrWidth-1:AddrWidth-2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_sel)
      REG_PATTERN_BYTES:  prdata = pat_bytes_r;
      REG_PATTERN_LENGTH: prdata = {{(DataWidth-LenWidth){1'b0}}, pat_len_r};
      REG_TEXT_LENGTH:    prdata = {{(DataWidth-TextLenWidth){1'b0}}, text_len_r};
      default:            prdata = {{(DataWidth-StartWidth){1'b0}}, start_idx_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= '0;
      text_len_r  <= '0;
      start_idx_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PATTERN_BYTES:  pat_bytes_r <= pwdata;
        REG_PATTERN_LENGTH: pat_len_r   <= pwdata[LenWidth-1:0];
        REG_TEXT_LENGTH:    text_len_r  <= pwdata[TextLenWidth-1:0];
        REG_START_INDEX:    start_idx_r <= pwdata[StartWidth-1:0];
        default: ;
      endcase
    end
  end

  // resolved 0-based start
  always_comb begin
    start_ext = {start_idx_r[StartWidth-1], start_idx_r};
    if (start_ext[StartWidth])
      start_adj = start_ext + {{(StartWidth+1-TextLenWidth){1'b0}}, text_len_r}
                  + {{StartWidth{1'b0}}, 1'b1};
    else
      start_adj = start_ext;
    if (!start_adj[StartWidth] && (start_adj != '0))
      start_res = start_adj[StartWidth-1:0] - {{(StartWidth-1){1'b0}}, 1'b1};
    else
      start_res = '0;
  end

  assign window  = {recent_r, s1_data_r.text_byte};
  assign beyond  = (pos_r == {PositionWidth{1'b1}});
  assign pos_nxt = beyond ? pos_r : pos_r + {{(PositionWidth-1){1'b0}}, 1'b1};
  assign first0  = pos_nxt - {{(PositionWidth-LenWidth){1'b0}}, pat_len_r};

  // per-length window compare, newest byte is the last pattern byte
  always_comb begin
    for (int l = 1; l <= PatternMax; l++) begin
      len_match[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (window[8*(l-1-k) +: 8] != pat_bytes_r[8*k +: 8])
          len_match[l] = 1'b0;
      end
    end
    win_match = 1'b0;
    for (int l = 1; l <= PatternMax; l++) begin
      if (pat_len_r == LenWidth'(l))
        win_match = len_match[l];
    end
  end

  assign match = !reported_r && !beyond && win_match
                 && (pos_nxt >= {{(PositionWidth-LenWidth){1'b0}}, pat_len_r})
                 && (pos_nxt <= text_len_r)
                 && ({1'b0, first0} >= start_res);
  assign emit  = match || (s1_data_r.last_byte && !reported_r);

  assign s1_adv    = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r   <= '0;
      pos_r      <= '0;
      reported_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_data_r.last_byte) begin
        recent_r   <= '0;
        pos_r      <= '0;
        reported_r <= 1'b0;
      end else begin
        recent_r   <= window[RecentWidth-1:0];
        pos_r      <= pos_nxt;
        reported_r <= reported_r || match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data_r.found          <= match;
      out_data_r.first_position <= match ? first0 + {{(PositionWidth-1){1'b0}}, 1'b1} : '0;
      out_data_r.last_position  <= match ? pos_nxt : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
